>>> rtl/core/lfuwb_pkg.sv
// Shared types and constants for the LFU write-back cache directory.
// Depends on nothing; every module of the block imports it.
package lfuwb_pkg;

    localparam int CL_W          = 32;
    localparam int CNT_W         = 16;
    localparam int SLOT_W        = 3;
    localparam int CAP_W         = 4;
    localparam int MAX_SLOTS_DEF = 8;

    localparam logic [CAP_W-1:0] CAP_RESET = 4'd1;
    localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;
    localparam logic [CNT_W-1:0] COUNT_ONE = 16'd1;

    typedef enum logic [1:0] {
        ACT_READ  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_FLUSH = 2'd2,
        ACT_DROP  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_VICT,
        S_DONE
    } t_state;

    typedef struct packed {
        t_action             action;
        logic [CL_W-1:0]     cluster;
    } t_req;

    typedef struct packed {
        logic                hit;
        logic [SLOT_W-1:0]   slot;
        logic                bypass;
        logic                fetch;
        logic                writeback;
        logic [CL_W-1:0]     victim_cluster;
        logic [SLOT_W-1:0]   victim_slot;
        logic                last;
    } t_res;

    // One directory entry as it travels around the ring.
    typedef struct packed {
        logic [CL_W-1:0]     tag;
        logic [CNT_W-1:0]    count;
        logic                dirty;
    } t_entry;

    // Change applied to an entry as it enters a cell.
    typedef struct packed {
        logic                load;
        logic                bump;
        logic                clr;
        logic                wr;
        logic [CL_W-1:0]     tag;
    } t_edit;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] cnt);
        logic [CNT_W-1:0] res;
        res = (cnt == COUNT_MAX) ? cnt : cnt + COUNT_ONE;
        return res;
    endfunction

endpackage

>>> rtl/core/lfu_writeback_block_cache_directory_core.sv
// Top level of the LFU write-back cache directory: a ring of directory cells
// and the head controller. Depends on lfuwb_pkg, lfuwb_cell and lfuwb_ctrl.
//
//  channel   direction   handshake              word
//  in        in          i_in_valid/o_in_stall  t_req  (action, cluster)
//  out       out         o_out_valid/i_out_stall t_res (hit .. last)
//  cfg       in          i_cfg_valid/o_cfg_ready block_capacity, 4 bits
//
// The directory entries rotate one cell per cycle past the head controller during a pass,
// unless a stall on the result side holds the ring. A replacement in a full cache needs a
// second pass to write the victim slot. One request is in work at a time.
// Reset empties the directory and sets the capacity to 1; no clearing pass is needed.
// A stall on the result side holds the ring during a flush or drop once a second dirty slot is found.
module lfu_writeback_block_cache_directory_core import lfuwb_pkg::*; #(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_req             i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_res             o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CAP_W-1:0] i_cfg_data
);

    t_entry w_cell      [MAX_SLOTS];
    t_entry w_cell_in   [MAX_SLOTS];
    t_edit  w_cell_edit [MAX_SLOTS];
    logic   w_shift;
    t_edit  w_edit;

    lfuwb_ctrl #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_head      (w_cell[0]),
        .o_shift     (w_shift),
        .o_edit      (w_edit)
    );

    // cell 0 is the head; the edited head entry re-enters at the tail
    for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_cell
        if (g == MAX_SLOTS - 1) begin : g_tail
            assign w_cell_in[g]   = w_cell[0];
            assign w_cell_edit[g] = w_edit;
        end else begin : g_body
            assign w_cell_in[g]   = w_cell[g+1];
            assign w_cell_edit[g] = '0;
        end

        lfuwb_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (w_shift),
            .i_entry (w_cell_in[g]),
            .i_edit  (w_cell_edit[g]),
            .o_entry (w_cell[g])
        );
    end

endmodule

>>> rtl/core/lfuwb_cell.sv
// One directory cell of the rotating ring: holds a slot's tag, use count and dirty mark.
// Depends on lfuwb_pkg for the entry and edit types.
module lfuwb_cell import lfuwb_pkg::*; (
    input  logic   i_clk,
    input  logic   i_shift,
    input  t_entry i_entry,
    input  t_edit  i_edit,
    output t_entry o_entry
);

    t_entry r_entry;
    t_entry n_entry;

    always_comb begin
        n_entry = i_entry;
        if (i_edit.load) begin
            n_entry.tag   = i_edit.tag;
            n_entry.count = COUNT_ONE;
            n_entry.dirty = i_edit.wr;
        end else begin
            if (i_edit.bump) begin
                n_entry.count = sat_inc(i_entry.count);
                if (i_edit.wr) begin
                    n_entry.dirty = 1'b1;
                end
            end
            if (i_edit.clr) begin
                n_entry.dirty = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_entry <= n_entry;
        end
    end

    assign o_entry = r_entry;

endmodule

>>> rtl/core/lfuwb_ctrl.sv
// Head controller: examines the entry at the head of the ring, edits it on its way
// to the tail, sequences each request and holds the result register. Uses lfuwb_pkg.
module lfuwb_ctrl import lfuwb_pkg::*; #(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_req             i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_res             o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CAP_W-1:0] i_cfg_data,
    input  t_entry           i_head,
    output logic             o_shift,
    output t_edit            o_edit
);

    localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int UW = $clog2(MAX_SLOTS + 1);
    localparam logic [IW-1:0] STEP_LAST = IW'(MAX_SLOTS - 1);

    t_state            r_state,     n_state;
    logic [CAP_W-1:0]  r_cap;
    logic [UW-1:0]     r_used,      n_used;
    logic [IW-1:0]     r_step,      n_step;
    t_action           r_act,       n_act;
    logic [CL_W-1:0]   r_cl,        n_cl;
    logic              r_bypass,    n_bypass;
    logic              r_hit,       n_hit;
    logic              r_fill,      n_fill;
    logic [IW-1:0]     r_slot,      n_slot;
    logic [IW-1:0]     r_best_idx,  n_best_idx;
    logic [CNT_W-1:0]  r_best_cnt,  n_best_cnt;
    logic [CL_W-1:0]   r_best_tag,  n_best_tag;
    logic              r_best_dirty, n_best_dirty;
    logic              r_pend_v,    n_pend_v;
    logic [IW-1:0]     r_pend_idx,  n_pend_idx;
    logic [CL_W-1:0]   r_pend_tag,  n_pend_tag;
    logic              r_out_valid, n_out_valid;
    t_res              r_out,       n_out;

    logic [UW-1:0]     w_cap;
    logic [UW-1:0]     w_k;
    logic              w_in_use;
    logic              w_wr;
    logic              w_wrap;
    logic              w_out_free;
    logic              w_hold;
    logic              w_load_out;
    t_res              w_res;
    logic              w_shift;
    t_edit             w_edit;

    assign o_in_stall  = (r_state != S_IDLE) || !i_rst_n;
    assign o_cfg_ready = i_rst_n;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_shift     = w_shift;
    assign o_edit      = w_edit;

    always_comb begin
        n_state      = r_state;
        n_used       = r_used;
        n_step       = r_step;
        n_act        = r_act;
        n_cl         = r_cl;
        n_bypass     = r_bypass;
        n_hit        = r_hit;
        n_fill       = r_fill;
        n_slot       = r_slot;
        n_best_idx   = r_best_idx;
        n_best_cnt   = r_best_cnt;
        n_best_tag   = r_best_tag;
        n_best_dirty = r_best_dirty;
        n_pend_v     = r_pend_v;
        n_pend_idx   = r_pend_idx;
        n_pend_tag   = r_pend_tag;
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        w_shift      = 1'b0;
        w_edit       = '0;
        w_load_out   = 1'b0;
        w_res        = '0;
        w_hold       = 1'b0;

        w_cap      = (int'(r_cap) > MAX_SLOTS) ? UW'(MAX_SLOTS) : UW'(r_cap);
        w_k        = UW'(r_step);
        w_in_use   = (w_k < r_used);
        w_wr       = (r_act == ACT_WRITE);
        w_wrap     = (r_step == STEP_LAST);
        w_out_free = !r_out_valid || !i_out_stall;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_act    = i_in_data.action;
                    n_cl     = i_in_data.cluster;
                    n_step   = '0;
                    n_hit    = 1'b0;
                    n_fill   = 1'b0;
                    n_pend_v = 1'b0;
                    n_bypass = ((i_in_data.action == ACT_READ) ||
                                (i_in_data.action == ACT_WRITE)) && (w_cap == '0);
                    n_state  = n_bypass ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                if ((r_act == ACT_FLUSH) || (r_act == ACT_DROP)) begin
                    w_edit.clr = (r_act == ACT_DROP);
                    if (w_in_use && i_head.dirty) begin
                        // report the previous dirty slot, now known not to be the last
                        if (r_pend_v) begin
                            if (w_out_free) begin
                                w_load_out           = 1'b1;
                                w_res.writeback      = 1'b1;
                                w_res.slot           = SLOT_W'(r_pend_idx);
                                w_res.victim_cluster = r_pend_tag;
                                w_res.victim_slot    = SLOT_W'(r_pend_idx);
                            end else begin
                                w_hold = 1'b1;
                            end
                        end
                        if (!w_hold) begin
                            n_pend_v   = 1'b1;
                            n_pend_idx = r_step;
                            n_pend_tag = i_head.tag;
                        end
                    end
                end else begin
                    if (w_in_use && !r_hit && (i_head.tag == r_cl)) begin
                        w_edit.bump = 1'b1;
                        w_edit.wr   = w_wr;
                        n_hit       = 1'b1;
                        n_slot      = r_step;
                    end else if (!r_hit && !r_fill && (w_k == r_used) && (r_used < w_cap)) begin
                        // first free slot: all used slots are already behind us
                        w_edit.load = 1'b1;
                        w_edit.wr   = w_wr;
                        w_edit.tag  = r_cl;
                        n_fill      = 1'b1;
                        n_slot      = r_step;
                        n_used      = r_used + UW'(1);
                    end
                    if (w_in_use && ((r_step == '0) || (i_head.count < r_best_cnt))) begin
                        n_best_idx   = r_step;
                        n_best_cnt   = i_head.count;
                        n_best_tag   = i_head.tag;
                        n_best_dirty = i_head.dirty;
                    end
                end
                if (!w_hold) begin
                    w_shift = 1'b1;
                    n_step  = w_wrap ? '0 : r_step + IW'(1);
                    if (w_wrap) begin
                        if ((r_act == ACT_FLUSH) || (r_act == ACT_DROP)) begin
                            n_state = S_DONE;
                            if (r_act == ACT_DROP) begin
                                n_used = '0;
                            end
                        end else if (n_hit || n_fill) begin
                            n_state = S_DONE;
                        end else begin
                            n_state = S_VICT;
                        end
                    end
                end
            end
            S_VICT: begin
                w_shift = 1'b1;
                if (r_step == r_best_idx) begin
                    w_edit.load = 1'b1;
                    w_edit.wr   = w_wr;
                    w_edit.tag  = r_cl;
                end
                n_step = w_wrap ? '0 : r_step + IW'(1);
                if (w_wrap) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    w_load_out = 1'b1;
                    w_res.last = 1'b1;
                    priority if ((r_act == ACT_FLUSH) || (r_act == ACT_DROP)) begin
                        if (r_pend_v) begin
                            w_res.writeback      = 1'b1;
                            w_res.slot           = SLOT_W'(r_pend_idx);
                            w_res.victim_cluster = r_pend_tag;
                            w_res.victim_slot    = SLOT_W'(r_pend_idx);
                        end
                    end else if (r_bypass) begin
                        w_res.bypass = 1'b1;
                        w_res.fetch  = !w_wr;
                    end else if (r_hit) begin
                        w_res.hit  = 1'b1;
                        w_res.slot = SLOT_W'(r_slot);
                    end else if (r_fill) begin
                        w_res.slot  = SLOT_W'(r_slot);
                        w_res.fetch = !w_wr;
                    end else begin
                        w_res.slot      = SLOT_W'(r_best_idx);
                        w_res.fetch     = !w_wr;
                        w_res.writeback = r_best_dirty;
                        if (r_best_dirty) begin
                            w_res.victim_cluster = r_best_tag;
                            w_res.victim_slot    = SLOT_W'(r_best_idx);
                        end
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_load_out) begin
            n_out_valid = 1'b1;
            n_out       = w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cap       <= CAP_RESET;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_step       <= n_step;
        r_act        <= n_act;
        r_cl         <= n_cl;
        r_bypass     <= n_bypass;
        r_hit        <= n_hit;
        r_fill       <= n_fill;
        r_slot       <= n_slot;
        r_best_idx   <= n_best_idx;
        r_best_cnt   <= n_best_cnt;
        r_best_tag   <= n_best_tag;
        r_best_dirty <= n_best_dirty;
        r_pend_v     <= n_pend_v;
        r_pend_idx   <= n_pend_idx;
        r_pend_tag   <= n_pend_tag;
        r_out        <= n_out;
    end

endmodule

>>> rtl/core/lfuwb_checker.sv
// Port-level checks for the LFU write-back cache directory, bound to the top level.
// Depends on lfuwb_pkg for the word types.
module lfuwb_checker import lfuwb_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input t_res o_out_data
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result word changed under stall");

    // one request in work at a time
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second request accepted while one is in work");

    a_hit_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.hit |->
            !o_out_data.writeback && !o_out_data.bypass && !o_out_data.fetch)
        else $error("hit word carries miss fields");

    a_victim_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.writeback |->
            (o_out_data.victim_cluster == '0) && (o_out_data.victim_slot == '0))
        else $error("victim fields set without writeback");

    // only a flush or drop gives more than one word; each but the last is a writeback
    a_multi_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.last |-> o_out_data.writeback && !o_out_data.hit)
        else $error("non-final word without writeback");

endmodule

bind lfu_writeback_block_cache_directory_core lfuwb_checker u_lfuwb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
